[design/tsrp_pkg.sv]
// Package for the tape stop read position block.
// Holds the field widths, the register and curve codes and the command and
// status types between the controller and the datapath. Depends on nothing.
package tsrp_pkg;

	localparam int POS_W        = 32;
	localparam int WHOLE_W      = 33;
	localparam int OUT_FRAC_W   = 16;
	localparam int START_W      = 34;
	localparam int CFG_DUR_W    = 21;
	localparam int CURVE_W      = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 21;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int MAX_DURATION_DEF = 1048576;
	localparam int DUR_RESET        = 48000;

	localparam logic [CFG_IDX_W-1:0] REG_DURATION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE    = 1'b1;

	localparam logic [CURVE_W-1:0] CURVE_LINEAR = 2'd0;
	localparam logic [CURVE_W-1:0] CURVE_SQUARE = 2'd1;
	localparam logic [CURVE_W-1:0] CURVE_ROOT   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic mul;
		logic root_init;
		logic root_step;
		logic finish;
	} tsrp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic curve_sq;
		logic curve_rt;
	} tsrp_stat_t;

endpackage

[design/tsrp_ctrl.sv]
// Controller of the tape stop read position block.
// Sequences the divider, the multiplier and the square root steps and owns
// the request handshakes. Depends on tsrp_pkg.
module tsrp_ctrl #(
	parameter int FRAC_BITS = tsrp_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  tsrp_pkg::tsrp_stat_t stat,
	output tsrp_pkg::tsrp_cmd_t  cmd
);

	localparam int SCW = $clog2(FRAC_BITS + 2);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIV   = 6'b000010,
		S_MUL   = 6'b000100,
		S_RINIT = 6'b001000,
		S_ROOT  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t         state_q, state_d;
	logic [SCW-1:0] step_q, step_d;
	logic           out_valid_q;
	logic           out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = '0;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + SCW'(1);
				if (step_q == SCW'(FRAC_BITS - 1)) begin
					step_d = '0;
					if (stat.curve_sq)
						state_d = S_MUL;
					else if (stat.curve_rt)
						state_d = S_RINIT;
					else
						state_d = S_DONE;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DONE;
			end
			S_RINIT: begin
				cmd.root_init = 1'b1;
				state_d       = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				step_d        = step_q + SCW'(1);
				if (step_q == SCW'(FRAC_BITS))
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[design/tsrp_dp.sv]
// Datapath of the tape stop read position block.
// Holds the configuration and cycle state, the restoring divider, the
// squaring multiplier, the square root unit and the result register.
// Depends on tsrp_pkg.
module tsrp_dp #(
	parameter int FRAC_BITS    = tsrp_pkg::FRAC_BITS_DEF,
	parameter int MAX_DURATION = tsrp_pkg::MAX_DURATION_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [tsrp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tsrp_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic [tsrp_pkg::POS_W-1:0]             write_position,
	input  tsrp_pkg::tsrp_cmd_t                    cmd,
	output tsrp_pkg::tsrp_stat_t                   stat,
	output logic signed [tsrp_pkg::WHOLE_W-1:0]    read_whole,
	output logic [tsrp_pkg::OUT_FRAC_W-1:0]        read_fraction,
	output logic                                   cycle_restart
);

	localparam int F   = FRAC_BITS;
	localparam int DW  = $clog2(MAX_DURATION + 1);
	localparam int EW  = (DW > tsrp_pkg::CFG_DUR_W) ? DW : tsrp_pkg::CFG_DUR_W;
	localparam int PW  = DW + F;
	localparam int SW  = tsrp_pkg::START_W;
	localparam int OFW = tsrp_pkg::OUT_FRAC_W;

	// Zero acts as one, and anything above the maximum saturates.
	function automatic logic [DW-1:0] clamp_dur(input logic [tsrp_pkg::CFG_DUR_W-1:0] v);
		logic [EW-1:0] ve;
		logic [EW-1:0] lim;
		ve  = EW'(v);
		lim = EW'(MAX_DURATION);
		if (ve == '0)
			ve = EW'(1);
		else if (ve > lim)
			ve = lim;
		return ve[DW-1:0];
	endfunction

	logic [DW-1:0]                 dur_q;
	logic [tsrp_pkg::CURVE_W-1:0]  curve_q;
	logic                          anchored_q;
	logic [SW-1:0]                 start_q;
	logic [PW-1:0]                 phase_q;
	logic [DW-1:0]                 count_q;
	logic                          restart_q;

	logic [DW-1:0]                 rem_q;
	logic [F-1:0]                  quo_q;
	logic [2*F+1:0]                prod_q;
	logic [2*F+1:0]                rad_q;
	logic [F+2:0]                  srem_q;
	logic [F:0]                    root_q;

	logic [tsrp_pkg::WHOLE_W-1:0]  whole_q;
	logic [OFW-1:0]                frac_q;
	logic                          restart_out_q;

	logic                          restart;
	logic [DW:0]                   rem2, dur_x, rem_diff;
	logic                          div_ge;
	logic [F:0]                    r_val;
	logic [F+2:0]                  srem_ext, trial, srem_diff;
	logic                          root_ge;
	logic [F:0]                    speed;
	logic [SW-1:0]                 whole_sum;
	logic [OFW-1:0]                frac_val;

	assign stat.curve_sq = (curve_q == tsrp_pkg::CURVE_SQUARE);
	assign stat.curve_rt = (curve_q == tsrp_pkg::CURVE_ROOT);

	assign restart = !anchored_q || (count_q >= dur_q);

	// One bit of count / duration per step; the count is always below the
	// duration here, so the quotient has only fraction bits.
	assign rem2     = {rem_q, 1'b0};
	assign dur_x    = {1'b0, dur_q};
	assign rem_diff = rem2 - dur_x;
	assign div_ge   = (rem2 >= dur_x);

	assign r_val = (F+1)'(1 << F) - {1'b0, quo_q};

	// Square root, two radicand bits per step.
	assign srem_ext  = {srem_q[F:0], rad_q[2*F+1:2*F]};
	assign trial     = {root_q, 2'b01};
	assign srem_diff = srem_ext - trial;
	assign root_ge   = (srem_ext >= trial);

	always_comb begin
		case (curve_q)
			tsrp_pkg::CURVE_SQUARE: speed = prod_q[2*F:F];
			tsrp_pkg::CURVE_ROOT:   speed = root_q;
			default:                speed = r_val;
		endcase
	end

	// The phase is never negative, so the floor of the read position is the
	// start plus the whole part of the phase.
	assign whole_sum = start_q + SW'(phase_q[PW-1:F]);

	generate
		if (F >= OFW) begin : g_frac_trunc
			assign frac_val = phase_q[F-1 -: OFW];
		end else begin : g_frac_pad
			assign frac_val = {phase_q[F-1:0], {(OFW-F){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q      <= clamp_dur(tsrp_pkg::CFG_DUR_W'(tsrp_pkg::DUR_RESET));
			curve_q    <= tsrp_pkg::CURVE_LINEAR;
			anchored_q <= 1'b0;
			start_q    <= '0;
			phase_q    <= '0;
			count_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tsrp_pkg::REG_DURATION:
						dur_q <= clamp_dur(cfg_data[tsrp_pkg::CFG_DUR_W-1:0]);
					tsrp_pkg::REG_CURVE:
						curve_q <= cfg_data[tsrp_pkg::CURVE_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.load && restart) begin
				start_q    <= {{(SW-tsrp_pkg::POS_W){1'b0}}, write_position} - SW'(dur_q);
				phase_q    <= '0;
				count_q    <= '0;
				anchored_q <= 1'b1;
			end else if (cmd.finish) begin
				phase_q <= phase_q + PW'(speed);
				count_q <= count_q + DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			restart_q <= restart;
			rem_q     <= restart ? '0 : count_q;
			quo_q     <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? rem_diff[DW-1:0] : rem2[DW-1:0];
			quo_q <= {quo_q[F-2:0], div_ge};
		end
		if (cmd.mul)
			prod_q <= (2*F+2)'(r_val * r_val);
		if (cmd.root_init) begin
			rad_q  <= (2*F+2)'({r_val, {F{1'b0}}});
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[2*F-1:0], 2'b00};
			srem_q <= root_ge ? srem_diff : srem_ext;
			root_q <= {root_q[F-1:0], root_ge};
		end
		if (cmd.finish) begin
			whole_q       <= whole_sum[tsrp_pkg::WHOLE_W-1:0];
			frac_q        <= frac_val;
			restart_out_q <= restart_q;
		end
	end

	assign read_whole    = $signed(whole_q);
	assign read_fraction = frac_q;
	assign cycle_restart = restart_out_q;

endmodule

[design/tape_stop_read_position.sv]
// Top level of the tape stop read position block.
// Joins the controller and the datapath. Depends on tsrp_pkg, tsrp_ctrl, tsrp_dp.
//
// Usage: each input request is one audio sample tick carrying the capture
// buffer write position; each tick gives exactly one output request with the
// read position (signed whole part, 16-bit fraction) and a restart flag.
// Both channels use valid and stall. One tick is worked on at a time: in_stall
// is high from the cycle after an accept until the result has been loaded into
// the output register. The divider gives one quotient bit per cycle; the square
// root unit adds a setup state and then two radicand bits per cycle, and the
// squared curve adds a multiply state. A new tick can be accepted in the cycle
// in which out_valid first goes high. The result waits in the output register
// while out_stall is high, and the next tick is taken and worked on meanwhile;
// it only waits at the end if the register is still full. Reset clears the
// cycle state, so the first tick re-anchors, and sets the duration to 48000
// samples and the linear curve. Configuration is written through cfg_we,
// cfg_index and cfg_data while idle; the block itself does not enforce this.
module tape_stop_read_position #(
	parameter int FRAC_BITS    = tsrp_pkg::FRAC_BITS_DEF,
	parameter int MAX_DURATION = tsrp_pkg::MAX_DURATION_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tsrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsrp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tsrp_pkg::POS_W-1:0]          write_position,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tsrp_pkg::WHOLE_W-1:0] read_whole,
	output logic [tsrp_pkg::OUT_FRAC_W-1:0]     read_fraction,
	output logic                                cycle_restart
);

	tsrp_pkg::tsrp_cmd_t  cmd;
	tsrp_pkg::tsrp_stat_t stat;

	tsrp_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tsrp_dp #(
		.FRAC_BITS   (FRAC_BITS),
		.MAX_DURATION(MAX_DURATION)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.write_position(write_position),
		.cmd           (cmd),
		.stat          (stat),
		.read_whole    (read_whole),
		.read_fraction (read_fraction),
		.cycle_restart (cycle_restart)
	);

endmodule

[design/tsrp_checker.sv]
// Port level checks for the tape stop read position block.
// Bound to the top level below. Depends on tsrp_pkg.
module tsrp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_we,
	input logic [tsrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [tsrp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [tsrp_pkg::POS_W-1:0]          write_position,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [tsrp_pkg::WHOLE_W-1:0] read_whole,
	input logic [tsrp_pkg::OUT_FRAC_W-1:0]     read_fraction,
	input logic                                cycle_restart
);

	// Only one tick is in flight, so an accept closes the input channel.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a tick was already in flight");

	// A new result appears only at the end of a tick's work.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no tick in flight");

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_whole)
			&& $stable(read_fraction) && $stable(cycle_restart))
		else $error("stalled result changed");

endmodule

bind tape_stop_read_position tsrp_checker u_tsrp_checker (.*);

[test/tb_tape_stop_read_position.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the tape stop read position block.
// Depends on tsrp_pkg and tape_stop_read_position; drives ticks and register
// writes and checks every result against a predictor of the read head or a typed value.
module tb_tape_stop_read_position;

	localparam int FRAC           = tsrp_pkg::FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIRECTED_ROWS  = 34;
	localparam int PHASES         = 16;
	localparam int TICKS_PER_PHASE = 100;

	typedef struct packed {
		logic [tsrp_pkg::WHOLE_W-1:0]    whole;
		logic [tsrp_pkg::OUT_FRAC_W-1:0] frac;
		logic                            restart;
	} read_pos_t;

	typedef struct packed {
		logic                            is_cfg;
		logic [tsrp_pkg::CFG_IDX_W-1:0]  index;
		logic [tsrp_pkg::CFG_DATA_W-1:0] data;
		logic [tsrp_pkg::POS_W-1:0]      wp;
		logic                            typed;
		logic [tsrp_pkg::WHOLE_W-1:0]    whole;
		logic [tsrp_pkg::OUT_FRAC_W-1:0] frac;
		logic                            restart;
	} stim_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [tsrp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [tsrp_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic [tsrp_pkg::POS_W-1:0]          write_position = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [tsrp_pkg::WHOLE_W-1:0] read_whole;
	logic [tsrp_pkg::OUT_FRAC_W-1:0]     read_fraction;
	logic                                cycle_restart;

	// Predictor copy of the registers and the stop cycle state.
	logic [tsrp_pkg::CFG_DUR_W-1:0] dur_reg = tsrp_pkg::CFG_DUR_W'(tsrp_pkg::DUR_RESET);
	logic [tsrp_pkg::CURVE_W-1:0]   curve_reg = tsrp_pkg::CURVE_LINEAR;
	bit                   head_anchored = 1'b0;
	longint               head_start = 0;
	longint unsigned      head_phase = 0;
	longint unsigned      head_played = 0;

	read_pos_t pending_reads[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int ticks_sent = 0;
	int cfg_writes = 0;
	int reads_checked = 0;
	int restarts_seen = 0;
	int negatives_seen = 0;
	int mismatches = 0;
	int stray_reads = 0;
	int idle_cycles = 0;

	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		// First ticks after reset: anchored 48000 samples back, full speed.
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd0, 1'b1, -33'sd48000, 16'd0, 1'b1},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd1, 1'b1, -33'sd47999, 16'd0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd2, 1'b0, '0, '0, 1'b0},
		// A zero duration acts as one, so every tick re-anchors one sample back.
		'{1'b1, tsrp_pkg::REG_DURATION, 21'd0, 32'd0, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'hFFFF_FFFF, 1'b1, 33'h0_FFFF_FFFE,
			16'd0, 1'b1},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd0, 1'b1, -33'sd1, 16'd0, 1'b1},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'h8000_0000, 1'b1, 33'h0_7FFF_FFFF,
			16'd0, 1'b1},
		// Oversized duration saturates; the unused curve code runs linear.
		'{1'b1, tsrp_pkg::REG_DURATION, 21'h1F_FFFF, 32'd0, 1'b0, '0, '0, 1'b0},
		'{1'b1, tsrp_pkg::REG_CURVE, 21'd3, 32'd0, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'h1234_5678, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'h1234_5679, 1'b0, '0, '0, 1'b0},
		'{1'b1, tsrp_pkg::REG_DURATION, 21'd4, 32'd0, 1'b0, '0, '0, 1'b0},
		'{1'b1, tsrp_pkg::REG_CURVE, {19'd0, tsrp_pkg::CURVE_SQUARE}, 32'd0, 1'b0, '0, '0,
			1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd100, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd101, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd102, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd103, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd104, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd105, 1'b0, '0, '0, 1'b0},
		'{1'b1, tsrp_pkg::REG_CURVE, {19'd0, tsrp_pkg::CURVE_ROOT}, 32'd0, 1'b0, '0, '0,
			1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd200, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd201, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd202, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd203, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd204, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd205, 1'b0, '0, '0, 1'b0},
		'{1'b1, tsrp_pkg::REG_DURATION, 21'd3, 32'd0, 1'b0, '0, '0, 1'b0},
		'{1'b1, tsrp_pkg::REG_CURVE, {19'd0, tsrp_pkg::CURVE_LINEAR}, 32'd0, 1'b0, '0, '0,
			1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd1, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd2, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd3, 1'b0, '0, '0, 1'b0},
		// Duration lowered below the count: the next tick must re-anchor.
		'{1'b1, tsrp_pkg::REG_DURATION, 21'd1, 32'd0, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd4, 1'b0, '0, '0, 1'b0},
		'{1'b0, tsrp_pkg::REG_DURATION, 21'd0, 32'd5, 1'b0, '0, '0, 1'b0}
	};

	tape_stop_read_position DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.write_position (write_position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_whole     (read_whole),
		.read_fraction  (read_fraction),
		.cycle_restart  (cycle_restart)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd1 << 20;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// Advances the read head by one tick and returns the position it reports.
	task automatic advance_read_head(input logic [tsrp_pkg::POS_W-1:0] wp,
			output read_pos_t res);
		longint unsigned dur, one, prog, rest, speed, frac_bits;
		longint pos;
		dur = longint'(dur_reg);
		if (dur == 0) dur = 1;
		if (dur > tsrp_pkg::MAX_DURATION_DEF) dur = tsrp_pkg::MAX_DURATION_DEF;
		one = 64'd1 << FRAC;
		res.restart = 1'b0;
		if (!head_anchored || head_played >= dur) begin
			head_start = longint'({32'd0, wp}) - longint'(dur);
			head_phase = 0;
			head_played = 0;
			head_anchored = 1'b1;
			res.restart = 1'b1;
		end
		prog = (head_played << FRAC) / dur;
		if (prog > one) prog = one;
		rest = one - prog;
		case (curve_reg)
			tsrp_pkg::CURVE_SQUARE: speed = (rest * rest) >> FRAC;
			tsrp_pkg::CURVE_ROOT:   speed = floor_root(rest << FRAC);
			default:                speed = rest;
		endcase
		pos = head_start * longint'(one) + longint'(head_phase);
		res.whole = tsrp_pkg::WHOLE_W'(pos >>> FRAC);
		frac_bits = longint'(pos) & (one - 1);
		if (FRAC >= tsrp_pkg::OUT_FRAC_W)
			res.frac = tsrp_pkg::OUT_FRAC_W'(frac_bits >> (FRAC - tsrp_pkg::OUT_FRAC_W));
		else
			res.frac = tsrp_pkg::OUT_FRAC_W'(frac_bits << (tsrp_pkg::OUT_FRAC_W - FRAC));
		head_phase += speed;
		head_played += 1;
	endtask

	// Called at a falling edge; returns at the falling edge after the accept.
	task automatic send_tick(input logic [tsrp_pkg::POS_W-1:0] wp, input bit typed,
			input read_pos_t typed_read);
		read_pos_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		write_position <= wp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_read_head(wp, predicted);
		pending_reads.push_back(typed ? typed_read : predicted);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Registers may only change once every outstanding request has drained.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_reads.size() > 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_register(input logic [tsrp_pkg::CFG_IDX_W-1:0] idx,
			input logic [tsrp_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cfg_writes++;
		if (idx == tsrp_pkg::REG_DURATION) dur_reg = data;
		else curve_reg = data[tsrp_pkg::CURVE_W-1:0];
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		read_pos_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reads.size() == 0) begin
				stray_reads++;
				if (mismatches + stray_reads <= 10)
					$display("%0t: read position with no tick outstanding: whole %0d",
						$realtime, read_whole);
			end else begin
				want = pending_reads.pop_front();
				reads_checked++;
				if (cycle_restart) restarts_seen++;
				if (read_whole[tsrp_pkg::WHOLE_W-1]) negatives_seen++;
				if (read_whole !== want.whole || read_fraction !== want.frac ||
						cycle_restart !== want.restart) begin
					mismatches++;
					if (mismatches + stray_reads <= 10)
						$display("%0t: read %0d: whole %0d/%0d frac %0d/%0d restart %0b/%0b",
							$realtime, reads_checked, $signed(want.whole), read_whole,
							want.frac, read_fraction, want.restart, cycle_restart);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic [tsrp_pkg::POS_W-1:0] wp;
		logic [tsrp_pkg::CFG_DUR_W-1:0] dur;
		read_pos_t typed_read;
		int pick;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				write_register(directed_rows[i].index, directed_rows[i].data);
			end else begin
				typed_read = '{directed_rows[i].whole, directed_rows[i].frac,
					directed_rows[i].restart};
				send_tick(directed_rows[i].wp, directed_rows[i].typed, typed_read);
			end
		end

		wp = $urandom();
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 69; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 69; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			// Short cycles dominate so that many stop cycles run to their end.
			pick = $urandom_range(99);
			if (ph == 0) dur = 21'h10_0000;
			else if (ph == 1) dur = 21'd0;
			else if (ph == 2) dur = 21'h1F_FFFF;
			else if (ph == 3) dur = 21'd1;
			else if (pick < 70) dur = tsrp_pkg::CFG_DUR_W'($urandom_range(1, 40));
			else if (pick < 90) dur = tsrp_pkg::CFG_DUR_W'($urandom_range(41, 400));
			else dur = tsrp_pkg::CFG_DUR_W'($urandom());
			wait_idle();
			write_register(tsrp_pkg::REG_DURATION, dur);
			write_register(tsrp_pkg::REG_CURVE, tsrp_pkg::CFG_DATA_W'($urandom()));
			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				pick = $urandom_range(99);
				if (pick < 80) wp = wp + 1;
				else if (pick < 88) wp = $urandom();
				else if (pick < 93) wp = wp;
				else wp = tsrp_pkg::POS_W'($urandom_range(0, 2000));
				send_tick(wp, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_reads.size() > 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("Sent %0d sample ticks over %0d register writes and all four curve codes.",
			ticks_sent, cfg_writes);
		$display("Checked %0d read positions: %0d restarts, %0d negative, %0d wrong, %0d stray.",
			reads_checked, restarts_seen, negatives_seen, mismatches, stray_reads);
		if (mismatches == 0 && stray_reads == 0 && pending_reads.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
